/* rtl/accel_tilt_estimator_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the accelerometer tilt estimator
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ESTIMATOR_ASSERT_SVH
`define ACCEL_TILT_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define ATE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ate_pkg.sv */
// ---------------------------------------------------------------------------
// ate_pkg
// Shared types, constants and helper functions of the tilt estimator.
// ---------------------------------------------------------------------------
`default_nettype none

package ate_pkg;

    localparam int CORDIC_ITER_DEF = 16;
    localparam int ATAN_IDX_W      = 5;      // index covers table entries 0 to 31
    localparam int AXIS_W          = 16;
    localparam int ANGLE_W         = 15;
    localparam int WEIGHT_W        = 9;
    localparam int ACC_W           = 24;
    localparam int CX_W            = 27;     // CORDIC x/y, sample * 256 plus gain
    localparam int CZ_W            = 25;     // CORDIC angle, 1/16384 degree
    localparam int FIFO_DEPTH      = 2;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = 9'd26;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_FULL  = 9'd256;
    localparam logic signed [CZ_W-1:0] HALF_TURN   = 25'sd2949120;
    localparam logic signed [CZ_W-1:0] LIMIT_HI    = 25'sd11520;
    localparam logic signed [CZ_W-1:0] LIMIT_LO    = -25'sd11520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd11520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd11520;

    typedef struct packed {
        logic                   zero;   // both operands zero: angle is 0
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_vec;

    typedef struct packed {
        t_vec pitch;
        t_vec roll;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // atan(2^-i) in 1/16384 degree
    function automatic logic signed [CZ_W-1:0] atan_fine(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd737280;
            5'd1:    v = 25'sd435242;
            5'd2:    v = 25'sd229970;
            5'd3:    v = 25'sd116736;
            5'd4:    v = 25'sd58595;
            5'd5:    v = 25'sd29326;
            5'd6:    v = 25'sd14667;
            5'd7:    v = 25'sd7334;
            5'd8:    v = 25'sd3667;
            5'd9:    v = 25'sd1833;
            5'd10:   v = 25'sd917;
            5'd11:   v = 25'sd458;
            5'd12:   v = 25'sd229;
            5'd13:   v = 25'sd115;
            5'd14:   v = 25'sd57;
            5'd15:   v = 25'sd29;
            5'd16:   v = 25'sd14;
            5'd17:   v = 25'sd7;
            5'd18:   v = 25'sd4;
            5'd19:   v = 25'sd2;
            5'd20:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round 1/16384 degree to 1/64 degree, saturate
    function automatic logic signed [ANGLE_W-1:0] fine_to_out(input logic signed [CZ_W-1:0] fine);
        logic signed [CZ_W-1:0] t;
        logic signed [ANGLE_W-1:0] r;
        t = (fine + 25'sd128) >>> 8;
        if (t > LIMIT_HI) begin
            r = ANGLE_MAX;
        end else if (t < LIMIT_LO) begin
            r = ANGLE_MIN;
        end else begin
            r = t[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ate_ifs.sv */
// ---------------------------------------------------------------------------
// ate_in_if / ate_out_if
// Valid/ready channels for sample words and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface ate_in_if import ate_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface ate_out_if import ate_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_raw;
    logic signed [ANGLE_W-1:0] roll_raw;
    logic signed [ANGLE_W-1:0] pitch_smoothed;
    logic signed [ANGLE_W-1:0] roll_smoothed;

    modport source (output valid, output pitch_raw, output roll_raw,
                    output pitch_smoothed, output roll_smoothed, input ready);
    modport sink   (input valid, input pitch_raw, input roll_raw,
                    input pitch_smoothed, input roll_smoothed, output ready);
endinterface

`default_nettype wire

/* rtl/ate_front.sv */
// ---------------------------------------------------------------------------
// ate_front
// Accepts sample words and sets up both CORDIC start vectors.
// ---------------------------------------------------------------------------
`default_nettype none

module ate_front import ate_pkg::*; (
    ate_in_if.sink     i_in,
    input  wire logic  i_full,
    output logic       o_push,
    output t_job       o_job
);

    // zero check, half-turn pre-rotation for a negative denominator
    function automatic t_vec prep(input logic signed [AXIS_W-1:0] num,
                                  input logic signed [AXIS_W-1:0] den);
        t_vec v;
        logic signed [CX_W-1:0] xd;
        logic signed [CX_W-1:0] yd;
        xd = CX_W'(den) <<< 8;
        yd = CX_W'(num) <<< 8;
        v.zero = (num == '0) && (den == '0);
        if (den[AXIS_W-1]) begin
            v.x = -xd;
            v.y = -yd;
            v.z = num[AXIS_W-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            v.x = xd;
            v.y = yd;
            v.z = '0;
        end
        return v;
    endfunction

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_job.pitch = prep(i_in.accel_x, i_in.accel_z);
        o_job.roll  = prep(i_in.accel_y, i_in.accel_z);
    end

endmodule

`default_nettype wire

/* rtl/ate_fifo.sv */
// ---------------------------------------------------------------------------
// ate_fifo
// Two-entry show-ahead queue between front end and CORDIC back end.
// ---------------------------------------------------------------------------
`default_nettype none

module ate_fifo import ate_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_data,
    input  wire logic  i_pop,
    output t_job       o_data,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

/* rtl/ate_back.sv */
// ---------------------------------------------------------------------------
// ate_back
// Iterative dual CORDIC, rounding, exponential filters and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ate_back import ate_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    input  wire t_job                i_job,
    input  wire t_fifo_stat          i_stat,
    output logic                     o_pop,
    ate_out_if.source                o_out
);

    localparam int IW  = $clog2(CORDIC_ITERATIONS);
    localparam int D_W = ACC_W + 2;
    localparam int P_W = D_W + WEIGHT_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [IW-1:0]             r_cnt;
    t_vec                      r_pv, r_rv;
    logic signed [ANGLE_W-1:0] r_praw, r_rraw;
    logic signed [P_W-1:0]     r_pprod, r_rprod;
    logic signed [ACC_W-1:0]   r_pacc, r_racc;
    logic signed [ACC_W-1:0]   n_pacc, n_racc;
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_o_praw, r_o_rraw, r_o_psm, r_o_rsm;

    logic [WEIGHT_W-1:0]       w_sat;
    logic signed [WEIGHT_W:0]  w_s;
    logic signed [D_W-1:0]     pd, rd;
    logic                      out_free;

    function automatic t_vec cordic_step(input t_vec v, input logic [IW-1:0] i);
        t_vec r;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [CZ_W-1:0] a;
        xs = v.x >>> i;
        ys = v.y >>> i;
        a  = atan_fine(ATAN_IDX_W'(i));
        r.zero = v.zero;
        if (!v.y[CX_W-1] && (v.y != '0)) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + a;
        end else begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - a;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_next(input logic signed [ACC_W-1:0] acc,
                                                         input logic signed [P_W-1:0] prod);
        logic signed [P_W-1:0] t;
        t = (prod + P_W'(128)) >>> 8;
        return acc + t[ACC_W-1:0];
    endfunction

    assign w_sat    = (i_weight > WEIGHT_FULL) ? WEIGHT_FULL : i_weight;
    assign w_s      = signed'({1'b0, w_sat});
    assign pd       = (D_W'(r_praw) <<< 8) - D_W'(r_pacc);
    assign rd       = (D_W'(r_rraw) <<< 8) - D_W'(r_racc);
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_stat.empty;
    assign n_pacc   = acc_next(r_pacc, r_pprod);
    assign n_racc   = acc_next(r_racc, r_rprod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_stat.empty) n_state = S_RUN;
            S_RUN:   if (r_cnt == IW'(CORDIC_ITERATIONS - 1)) n_state = S_ROUND;
            S_ROUND: n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pv <= i_job.pitch;
                r_rv <= i_job.roll;
            end
            S_RUN: begin
                r_pv <= cordic_step(r_pv, r_cnt);
                r_rv <= cordic_step(r_rv, r_cnt);
            end
            S_ROUND: begin
                // pitch is the negated angle
                r_praw <= r_pv.zero ? '0 : fine_to_out(-r_pv.z);
                r_rraw <= r_rv.zero ? '0 : fine_to_out(r_rv.z);
            end
            S_MUL: begin
                r_pprod <= w_s * pd;
                r_rprod <= w_s * rd;
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_o_praw <= r_praw;
            r_o_rraw <= r_rraw;
            r_o_psm  <= fine_to_out(CZ_W'(n_pacc));
            r_o_rsm  <= fine_to_out(CZ_W'(n_racc));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pacc      <= '0;
            r_racc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_DONE && out_free) begin
                r_pacc      <= n_pacc;
                r_racc      <= n_racc;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pitch_raw      = r_o_praw;
    assign o_out.roll_raw       = r_o_rraw;
    assign o_out.pitch_smoothed = r_o_psm;
    assign o_out.roll_smoothed  = r_o_rsm;

endmodule

`default_nettype wire

/* rtl/accel_tilt_estimator.sv */
// An accepted sample goes through the queue, the CORDIC iterations, rounding, the filter
// multiply and the output register. The back end finishes one sample before it takes the
// next, as it runs the iterative CORDIC for both angles in lockstep.
// The two-entry queue and the output register let input and output stall independently.
// Reset: synchronous, active low; clears control, filter state, weight to 26/256.
// ---------------------------------------------------------------------------
// accel_tilt_estimator
// Pitch/roll from a three-axis sample via CORDIC atan2, then low-pass filtered.
// ---------------------------------------------------------------------------
`default_nettype none
`include "accel_tilt_estimator_assert.svh"

module accel_tilt_estimator import ate_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [WEIGHT_W-1:0] i_cfg_wdata,
    ate_in_if.sink                   i_in,
    ate_out_if.source                o_out
);

    logic [WEIGHT_W-1:0] r_weight;
    logic                job_push;
    logic                job_pop;
    t_job                job_in;
    t_job                job_q;
    t_fifo_stat          fifo_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    ate_front u_front (
        .i_in   (i_in),
        .i_full (fifo_stat.full),
        .o_push (job_push),
        .o_job  (job_in)
    );

    ate_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_q),
        .o_stat  (fifo_stat)
    );

    ate_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_weight (r_weight),
        .i_job    (job_q),
        .i_stat   (fifo_stat),
        .o_pop    (job_pop),
        .o_out    (o_out)
    );

    `ATE_ASSERT_IMP(a_push_not_full, job_push, !fifo_stat.full, "push into full queue")
    `ATE_ASSERT_IMP(a_pop_not_empty, job_pop, !fifo_stat.empty, "pop from empty queue")
    `ATE_ASSERT_NXT(a_push_fills, job_push && !job_pop, !fifo_stat.empty, "queue empty after push")
    `ATE_ASSERT_IMP(a_raw_range, o_out.valid, (o_out.pitch_raw >= ANGLE_MIN) && (o_out.pitch_raw <= ANGLE_MAX), "pitch out of range")

endmodule

`default_nettype wire

/* tb/tb_accel_tilt_estimator.sv */
// ---------------------------------------------------------------------------
// tb_accel_tilt_estimator
// Sends three-axis samples into the tilt estimator and checks every result
// word against an in-bench CORDIC atan2 and filter model. Covers directed
// axis extremes, the 180-degree cases, the weight extremes, random phases
// with steady-tilt runs under random valid and ready gaps, and a gap-free run.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_accel_tilt_estimator;
    import ate_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int LIMIT_CYCLES = 600000;
    localparam int PRINT_CAP = 40;

    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_raw;
        logic signed [ANGLE_W-1:0] roll_raw;
        logic signed [ANGLE_W-1:0] pitch_smoothed;
        logic signed [ANGLE_W-1:0] roll_smoothed;
    } t_tilt_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [WEIGHT_W-1:0] i_cfg_wdata;

    ate_in_if in_if ();
    ate_out_if out_if ();

    accel_tilt_estimator #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // atan(2^-i) in 1/16384 degree
    longint atan_step_fine [24] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    t_tilt_word tilt_expected [$];
    logic [WEIGHT_W-1:0] weight_now;
    longint pitch_acc;
    longint roll_acc;

    int err_count;
    int samples_sent;
    int words_seen;
    int weight_writes;
    int cycles = 0;
    bit src_idle_on;
    bit snk_idle_on;

    // steady-tilt base vector for the random phases
    t_axis base_x, base_y, base_z;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------

    function automatic longint tilt_atan2_fine(input longint num, input longint den);
        longint vx, vy, ang, sx, sy;
        int i;
        if (num == 0 && den == 0) begin
            return 0;
        end
        vx = den * 256;
        vy = num * 256;
        ang = 0;
        if (den < 0) begin
            ang = (num >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
            vx = -vx;
            vy = -vy;
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + atan_step_fine[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - atan_step_fine[i];
            end
        end
        return ang;
    endfunction

    // 1/16384 degree -> 1/64 degree, round half up, saturate
    function automatic longint to_sixtyfourths(input longint fine);
        longint t;
        t = (fine + 128) >>> 8;
        if (t > longint'(ANGLE_MAX)) begin
            t = longint'(ANGLE_MAX);
        end else if (t < longint'(ANGLE_MIN)) begin
            t = longint'(ANGLE_MIN);
        end
        return t;
    endfunction

    function automatic longint smooth_step(input longint acc, input longint angle,
                                           input longint w);
        return acc + ((w * (angle * 256 - acc) + 128) >>> 8);
    endfunction

    task automatic predict_tilt(input t_axis ax, input t_axis ay, input t_axis az);
        longint w, p, r;
        t_tilt_word word;
        w = (weight_now > WEIGHT_FULL) ? longint'(WEIGHT_FULL) : longint'(weight_now);
        p = to_sixtyfourths(-tilt_atan2_fine(longint'(ax), longint'(az)));
        r = to_sixtyfourths(tilt_atan2_fine(longint'(ay), longint'(az)));
        pitch_acc = smooth_step(pitch_acc, p, w);
        roll_acc = smooth_step(roll_acc, r, w);
        word.pitch_raw = ANGLE_W'(p);
        word.roll_raw = ANGLE_W'(r);
        word.pitch_smoothed = ANGLE_W'(to_sixtyfourths(pitch_acc));
        word.roll_smoothed = ANGLE_W'(to_sixtyfourths(roll_acc));
        tilt_expected.push_back(word);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_tilt_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            words_seen++;
            if (tilt_expected.size() == 0) begin
                report_mismatch("unexpected word", int'(out_if.pitch_raw), 0);
            end else begin
                want = tilt_expected.pop_front();
                if (out_if.pitch_raw !== want.pitch_raw)
                    report_mismatch("pitch_raw", int'(out_if.pitch_raw), int'(want.pitch_raw));
                if (out_if.roll_raw !== want.roll_raw)
                    report_mismatch("roll_raw", int'(out_if.roll_raw), int'(want.roll_raw));
                if (out_if.pitch_smoothed !== want.pitch_smoothed)
                    report_mismatch("pitch_smoothed", int'(out_if.pitch_smoothed),
                                    int'(want.pitch_smoothed));
                if (out_if.roll_smoothed !== want.roll_smoothed)
                    report_mismatch("roll_smoothed", int'(out_if.roll_smoothed),
                                    int'(want.roll_smoothed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words pending", cycles,
                     tilt_expected.size());
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls
    initial begin : sink_stall
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ---------------- stimulus helpers ----------------

    // leaves valid high on return; the caller sends again or pauses in the same step
    task automatic send_sample(input t_axis ax, input t_axis ay, input t_axis az);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.accel_x <= ax;
        in_if.accel_y <= ay;
        in_if.accel_z <= az;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_tilt(ax, ay, az);
        samples_sent++;
    endtask

    task automatic pause_samples();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        pause_samples();
        while (tilt_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        weight_now = w;
        weight_writes++;
    endtask

    function automatic t_axis random_axis();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1, 2: return t_axis'($urandom_range(0, 80)) - t_axis'(40);
            3: begin
                case ($urandom_range(0, 6))
                    0: return t_axis'(-32768);
                    1: return t_axis'(-32767);
                    2: return t_axis'(-1);
                    3: return t_axis'(1);
                    4: return t_axis'(32766);
                    5: return t_axis'(32767);
                    default: return '0;
                endcase
            end
            default: return t_axis'($urandom_range(0, 65535));
        endcase
    endfunction

    // slowly varying vector around the base, so the filter tracks something real
    task automatic send_steady_sample();
        t_axis nx, ny, nz;
        nx = base_x + t_axis'($urandom_range(0, 64)) - t_axis'(32);
        ny = base_y + t_axis'($urandom_range(0, 64)) - t_axis'(32);
        nz = base_z + t_axis'($urandom_range(0, 64)) - t_axis'(32);
        send_sample(nx, ny, nz);
    endtask

    task automatic new_base();
        base_x = t_axis'($urandom_range(0, 32000)) - t_axis'(16000);
        base_y = t_axis'($urandom_range(0, 32000)) - t_axis'(16000);
        base_z = t_axis'($urandom_range(0, 32000)) - t_axis'(16000);
    endtask

    // ---------------- tests ----------------

    // reset weight is in effect; no register write yet
    task automatic test_directed_angles();
        send_sample(0, 0, 0);
        send_sample(0, 0, 1000);
        send_sample(1000, 0, 0);
        send_sample(-1000, 0, 0);
        send_sample(0, 1000, 0);
        send_sample(0, -1000, 0);
        send_sample(0, 0, -1000);               // exactly 180 degrees on both axes
        send_sample(-5, 5, -1000);              // just either side of 180
        send_sample(32767, 32767, 32767);
        send_sample(-32768, -32768, -32768);
        send_sample(-32768, 32767, 0);
        send_sample(32767, -32768, -32768);
        send_sample(1, -1, -1);
        send_sample(0, 0, -32768);
        pause_samples();
    endtask

    task automatic test_weight_extremes();
        logic [WEIGHT_W-1:0] wl [4];
        int k, n;
        wl = '{9'd0, 9'd256, 9'd511, 9'd257};
        for (k = 0; k < 4; k++) begin
            write_weight(wl[k]);
            for (n = 0; n < 3; n++) begin
                send_sample(random_axis(), random_axis(), random_axis());
            end
        end
        pause_samples();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int ph, n;
        logic [WEIGHT_W-1:0] w;
        for (ph = 0; ph < phases; ph++) begin
            case ($urandom_range(0, 5))
                0: w = 9'd1;
                1: w = WEIGHT_RESET;
                2: w = 9'd255;
                default: w = WEIGHT_W'($urandom_range(0, 511));
            endcase
            write_weight(w);
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            new_base();
            for (n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    send_steady_sample();
                end else begin
                    send_sample(random_axis(), random_axis(), random_axis());
                end
                if ($urandom_range(0, 49) == 0) begin
                    new_base();
                end
            end
        end
        pause_samples();
    endtask

    // back to back words at the end, no gaps on either side
    task automatic test_full_rate(input int count);
        int n;
        write_weight(9'd64);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        new_base();
        for (n = 0; n < count; n++) begin
            if (n % 2 == 0) begin
                send_steady_sample();
            end else begin
                send_sample(random_axis(), random_axis(), random_axis());
            end
        end
        pause_samples();
    endtask

    // ---------------- main ----------------

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        in_if.valid <= 1'b0;
        in_if.accel_x <= '0;
        in_if.accel_y <= '0;
        in_if.accel_z <= '0;
        err_count = 0;
        samples_sent = 0;
        words_seen = 0;
        weight_writes = 0;
        weight_now = WEIGHT_RESET;
        pitch_acc = 0;
        roll_acc = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_angles();
        test_weight_extremes();
        test_random_phases(9, 180);
        test_full_rate(170);

        while (tilt_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d samples, %0d result words, %0d weight settings",
                 samples_sent, words_seen, weight_writes);
        $display("axis extremes, 180-degree flips, weights 0/1/256/257/511, %0d mismatches",
                 err_count);
        if (err_count == 0 && tilt_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/ate_pkg.sv
rtl/ate_ifs.sv
rtl/ate_front.sv
rtl/ate_fifo.sv
rtl/ate_back.sv
rtl/accel_tilt_estimator.sv
tb/tb_accel_tilt_estimator.sv
